// File: hdl/kwnl_pkg.sv
package kwnl_pkg;

	// Default sizes
	localparam int DEFAULT_VALUE_WIDTH = 64;
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_QUERY  = 8'h3F;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_M      = 8'h6D;

	// Keyword lengths
	localparam logic [3:0] KW_CALL_LEN     = 4'd4;
	localparam logic [3:0] KW_MAKEPROC_LEN = 4'd8;

	typedef enum logic [2:0] {
		LM_IDLE,
		LM_KEYWORD,
		LM_IDENT,
		LM_INT,
		LM_DOLLAR,
		LM_VARNUM,
		LM_ERROR
	} lex_mode_t;

	typedef enum logic [3:0] {
		TAG_NEWLINE,
		TAG_ASSIGN,
		TAG_LABEL,
		TAG_MAYBE,
		TAG_CALL,
		TAG_MAKEPROC,
		TAG_INT,
		TAG_VARNUM,
		TAG_IDCHAR,
		TAG_IDEND,
		TAG_END,
		TAG_UNKNOWN,
		TAG_RANGE
	} tag_t;

	// One byte's worth of tokens: lead identifier letters, then up to two tags
	typedef struct packed {
		logic [2:0] lead;
		logic [1:0] ntags;
		tag_t       tag0;
		tag_t       tag1;
	} burst_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage

// File: hdl/kwnl_front.sv
module kwnl_front import kwnl_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] text_byte,
	output logic       push,
	output burst_t     burst
);

	localparam int PW = VALUE_WIDTH + 3;

	typedef struct packed {
		logic valid;
		tag_t tag;
	} start_t;

	lex_mode_t              mode_q, mode_d;
	logic                   choice_q, choice_d;
	logic [2:0]             matched_q, matched_d;
	logic [VALUE_WIDTH-2:0] acc_q, acc_d;

	logic          is_zero, is_letter, is_digit, is_kwstart;
	logic          kw_hit, kw_done, fin, ovf;
	logic [3:0]    digit_val;
	logic [PW-1:0] acc_ext, prod;
	logic [VALUE_WIDTH-2:0] acc_next;
	start_t        st;

	// Keyword letter at a given position
	function automatic logic [7:0] kw_char(input logic ch, input logic [2:0] idx);
		logic [7:0] c;
		c = CH_NUL;
		if (ch) begin
			case (idx)
				3'd0: c = "m";
				3'd1: c = "a";
				3'd2: c = "k";
				3'd3: c = "e";
				3'd4: c = "p";
				3'd5: c = "r";
				3'd6: c = "o";
				3'd7: c = "c";
				default: c = CH_NUL;
			endcase
		end else begin
			case (idx)
				3'd0: c = "c";
				3'd1: c = "a";
				3'd2: c = "l";
				3'd3: c = "l";
				default: c = CH_NUL;
			endcase
		end
		return c;
	endfunction

	// Tag given by a byte that opens a token
	function automatic start_t start_tag(input logic [7:0] b);
		start_t s;
		s.valid = 1'b0;
		s.tag   = TAG_UNKNOWN;
		case (b)
			CH_SPACE: s.valid = 1'b0;
			CH_NL:    begin s.valid = 1'b1; s.tag = TAG_NEWLINE; end
			CH_EQUAL: begin s.valid = 1'b1; s.tag = TAG_ASSIGN; end
			CH_COLON: begin s.valid = 1'b1; s.tag = TAG_LABEL; end
			CH_QUERY: begin s.valid = 1'b1; s.tag = TAG_MAYBE; end
			CH_C, CH_M, CH_DOLLAR: s.valid = 1'b0;
			default: begin
				if (b inside {["0":"9"]}) begin
					s.valid = 1'b0;
				end else if (b inside {["a":"z"], ["A":"Z"]}) begin
					s.valid = 1'b1;
					s.tag   = TAG_IDCHAR;
				end else begin
					s.valid = 1'b1;
					s.tag   = TAG_UNKNOWN;
				end
			end
		endcase
		return s;
	endfunction

	// Classify the byte
	assign is_zero    = (text_byte == CH_NUL);
	assign is_letter  = text_byte inside {["a":"z"], ["A":"Z"]};
	assign is_digit   = text_byte inside {["0":"9"]};
	assign is_kwstart = (text_byte == CH_C) || (text_byte == CH_M);
	assign digit_val  = text_byte[3:0];
	assign st         = start_tag(text_byte);

	// Keyword progress
	assign kw_hit  = !is_zero && (text_byte == kw_char(choice_q, matched_q));
	assign kw_done = (({1'b0, matched_q} + 4'd1) ==
		(choice_q ? KW_MAKEPROC_LEN : KW_CALL_LEN));

	// Accumulate times ten plus digit; any bit at or above the sign position overflows
	assign acc_ext  = {4'b0, acc_q};
	assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{(PW-4){1'b0}}, digit_val};
	assign ovf      = |prod[PW-1:VALUE_WIDTH-1];
	assign acc_next = prod[VALUE_WIDTH-2:0];

	// Decide whether the byte ends the pending token and opens a new one
	always_comb begin
		fin = 1'b0;
		case (mode_q)
			LM_KEYWORD:          fin = !kw_hit && !is_letter;
			LM_IDENT:            fin = !is_letter;
			LM_INT, LM_VARNUM:   fin = !is_digit;
			LM_DOLLAR, LM_ERROR: fin = 1'b0;
			default:             fin = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		mode_d    = mode_q;
		choice_d  = choice_q;
		matched_d = matched_q;
		acc_d     = acc_q;
		if (fin) begin
			mode_d    = LM_IDLE;
			choice_d  = 1'b0;
			matched_d = '0;
			acc_d     = '0;
			if (!is_zero) begin
				if (is_kwstart) begin
					mode_d    = LM_KEYWORD;
					choice_d  = (text_byte == CH_M);
					matched_d = 3'd1;
				end else if (is_digit) begin
					mode_d = LM_INT;
					acc_d  = {{(VALUE_WIDTH-5){1'b0}}, digit_val};
				end else if (text_byte == CH_DOLLAR) begin
					mode_d = LM_DOLLAR;
				end else if (is_letter) begin
					mode_d = LM_IDENT;
				end else if (st.valid && st.tag == TAG_UNKNOWN) begin
					mode_d = LM_ERROR;
				end
			end
		end else begin
			case (mode_q)
				LM_KEYWORD: begin
					if (kw_hit && !kw_done) begin
						matched_d = matched_q + 3'd1;
					end else begin
						mode_d    = kw_hit ? LM_IDLE : LM_IDENT;
						choice_d  = 1'b0;
						matched_d = '0;
					end
				end
				LM_INT, LM_VARNUM: begin
					if (ovf) begin
						mode_d = LM_ERROR;
						acc_d  = '0;
					end else begin
						acc_d = acc_next;
					end
				end
				LM_DOLLAR: begin
					if (is_digit) begin
						mode_d = LM_VARNUM;
						acc_d  = acc_next;
					end else begin
						mode_d = is_zero ? LM_IDLE : LM_ERROR;
					end
				end
				LM_ERROR: begin
					if (is_zero) mode_d = LM_IDLE;
				end
				default: mode_d = mode_q;
			endcase
		end
	end

	// Tokens caused by the byte
	always_comb begin
		logic [1:0] n;
		tag_t       t0, t1;
		logic [2:0] ld;
		n  = 2'd0;
		t0 = TAG_END;
		t1 = TAG_END;
		ld = 3'd0;
		case (mode_q)
			LM_KEYWORD: begin
				if (kw_hit) begin
					if (kw_done) begin
						n  = 2'd1;
						t0 = choice_q ? TAG_MAKEPROC : TAG_CALL;
					end
				end else begin
					ld = matched_q;
					n  = 2'd1;
					t0 = is_letter ? TAG_IDCHAR : TAG_IDEND;
				end
			end
			LM_IDENT: begin
				n  = 2'd1;
				t0 = is_letter ? TAG_IDCHAR : TAG_IDEND;
			end
			LM_INT, LM_VARNUM: begin
				if (is_digit) begin
					if (ovf) begin
						n  = 2'd1;
						t0 = TAG_RANGE;
					end
				end else begin
					n  = 2'd1;
					t0 = (mode_q == LM_INT) ? TAG_INT : TAG_VARNUM;
				end
			end
			LM_DOLLAR: begin
				if (!is_digit) begin
					n  = is_zero ? 2'd2 : 2'd1;
					t0 = TAG_UNKNOWN;
					t1 = TAG_END;
				end
			end
			LM_ERROR: begin
				if (is_zero) begin
					n  = 2'd1;
					t0 = TAG_END;
				end
			end
			default: n = 2'd0;
		endcase
		// Append the tag of the byte that opens the next token
		if (fin && (is_zero || st.valid)) begin
			if (n == 2'd0) begin
				t0 = is_zero ? TAG_END : st.tag;
			end else begin
				t1 = is_zero ? TAG_END : st.tag;
			end
			n = n + 2'd1;
		end
		burst.lead  = ld;
		burst.ntags = n;
		burst.tag0  = t0;
		burst.tag1  = t1;
	end

	assign push = take && ((burst.lead != 3'd0) || (burst.ntags != 2'd0));

	// Hold lexer state between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= LM_IDLE;
			choice_q  <= 1'b0;
			matched_q <= '0;
			acc_q     <= '0;
		end else if (take) begin
			mode_q    <= mode_d;
			choice_q  <= choice_d;
			matched_q <= matched_d;
			acc_q     <= acc_d;
		end
	end

endmodule

// File: hdl/kwnl_queue.sv
module kwnl_queue import kwnl_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t wdata,
	input  logic   pop,
	output burst_t rdata,
	output qstat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	burst_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign rdata      = mem_q[rd_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == FULL);

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/kwnl_back.sv
module kwnl_back import kwnl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  burst_t     head,
	input  logic       head_valid,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [3:0] token_tag
);

	logic [3:0] pos_q;
	logic [3:0] total;
	logic [3:0] lead4;
	logic       issue, last;
	tag_t       tag_q, tag_n;

	assign lead4 = {1'b0, head.lead};
	assign total = lead4 + {2'b0, head.ntags};
	assign issue = head_valid && (!out_valid || out_ready);
	assign last  = (pos_q == total - 4'd1);
	assign pop   = issue && last;

	// Pick the tag at the current position of the word
	always_comb begin
		if (pos_q < lead4) begin
			tag_n = TAG_IDCHAR;
		end else if (pos_q == lead4) begin
			tag_n = head.tag0;
		end else begin
			tag_n = head.tag1;
		end
	end

	// Advance through the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (issue) begin
				out_valid <= 1'b1;
				pos_q     <= last ? 4'd0 : pos_q + 4'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Hold the output tag
	always_ff @(posedge clk) begin
		if (issue) tag_q <= tag_n;
	end

	assign token_tag = tag_q;

endmodule

// File: hdl/keyword_number_lexer.sv
// A taken byte's tokens pass the front-to-back queue and an output register.
// Throughput: one byte per cycle in until the queue fills and in_ready drops, one
// token per cycle out while out_ready is high; a byte giving n tokens (up to nine)
// holds the token port until all are offered, the queue absorbing such bursts.
// Reset: arst_n clears lexer state, queue pointers and output valid at once.
module keyword_number_lexer import kwnl_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_tag
);

	logic   take, push, pop;
	burst_t wburst, head;
	qstat_t qstat;

	assign in_ready = !qstat.full;
	assign take     = in_valid && in_ready;

	kwnl_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_byte),
		.push      (push),
		.burst     (wburst)
	);

	kwnl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wburst),
		.pop    (pop),
		.rdata  (head),
		.stat   (qstat)
	);

	kwnl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (qstat.valid),
		.pop        (pop),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.token_tag  (token_tag)
	);

`ifndef SYNTHESIS
	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> qstat.valid)
		else $error("pop from empty queue");

	// A queued word always carries at least one token
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.valid |-> ((head.lead != 3'd0) || (head.ntags != 2'd0)))
		else $error("empty word in queue");

	// Offered tags stay within the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (token_tag <= 4'(TAG_RANGE)))
		else $error("undefined token tag");

	// A full queue that is not drained stays full and blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.full && !pop) |=> !in_ready)
		else $error("queue overrun");
`endif

endmodule

// File: tb/keyword_number_lexer_tb.sv
`timescale 1ns / 100ps

module keyword_number_lexer_tb import kwnl_pkg::*;;

	localparam int LITERAL_WIDTH = DEFAULT_VALUE_WIDTH;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int REPORT_LIMIT  = 10;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       out_valid;
	logic       out_ready;
	logic [3:0] token_tag;

	// Lexer state as predicted from the accepted words
	lex_mode_t   lex_mode;
	bit          kw_sel;
	logic [2:0]  kw_got;
	logic [63:0] literal_acc;
	tag_t        pending_tokens[$];

	logic [7:0] text_buf[$];
	int         send_idle_pct;
	int         recv_stall_pct;
	int         stall_left;
	int         bytes_taken;
	int         fail_count;
	int         cycle_count;

	keyword_number_lexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.token_tag (token_tag)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Character classes
	function automatic bit is_digit_byte(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_letter_byte(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic [7:0] keyword_char(bit sel, logic [2:0] idx);
		string w;
		w = sel ? "makeproc" : "call";
		return w[idx];
	endfunction

	function automatic void lex_clear();
		lex_mode    = LM_IDLE;
		kw_sel      = 1'b0;
		kw_got      = '0;
		literal_acc = '0;
	endfunction

	// Accumulate one digit; a literal past the signed limit raises range
	function automatic void lex_add_digit(logic [7:0] b);
		logic [63:0] lim;
		logic [63:0] d;
		lim = (64'd1 << (LITERAL_WIDTH - 1)) - 64'd1;
		d   = {56'd0, b - 8'h30};
		if (literal_acc > (lim - d) / 64'd10) begin
			pending_tokens.push_back(TAG_RANGE);
			lex_clear();
			lex_mode = LM_ERROR;
		end else begin
			literal_acc = literal_acc * 64'd10 + d;
		end
	endfunction

	// Open a token on a nonzero word
	function automatic void lex_start(logic [7:0] b);
		lex_clear();
		if (b == CH_SPACE)
			return;
		if (b == CH_NL)
			pending_tokens.push_back(TAG_NEWLINE);
		else if (b == CH_EQUAL)
			pending_tokens.push_back(TAG_ASSIGN);
		else if (b == CH_COLON)
			pending_tokens.push_back(TAG_LABEL);
		else if (b == CH_QUERY)
			pending_tokens.push_back(TAG_MAYBE);
		else if (b == CH_C || b == CH_M) begin
			lex_mode = LM_KEYWORD;
			kw_sel   = (b == CH_M);
			kw_got   = 3'd1;
		end else if (is_digit_byte(b)) begin
			lex_mode = LM_INT;
			lex_add_digit(b);
		end else if (b == CH_DOLLAR)
			lex_mode = LM_DOLLAR;
		else if (is_letter_byte(b)) begin
			lex_mode = LM_IDENT;
			pending_tokens.push_back(TAG_IDCHAR);
		end else begin
			pending_tokens.push_back(TAG_UNKNOWN);
			lex_mode = LM_ERROR;
		end
	endfunction

	// Work out the tokens that one accepted word gives
	function automatic void lex_byte(logic [7:0] b);
		logic [3:0] kw_len;
		case (lex_mode)
			LM_KEYWORD: begin
				kw_len = kw_sel ? KW_MAKEPROC_LEN : KW_CALL_LEN;
				if (b != CH_NUL && {1'b0, kw_got} < kw_len && b == keyword_char(kw_sel, kw_got)) begin
					if ({1'b0, kw_got} + 4'd1 == kw_len) begin
						if (kw_sel)
							pending_tokens.push_back(TAG_MAKEPROC);
						else
							pending_tokens.push_back(TAG_CALL);
						lex_clear();
					end else begin
						kw_got = kw_got + 3'd1;
					end
					return;
				end
				// failed keyword: matched letters become identifier letters
				for (int i = 0; i < kw_got; i++)
					pending_tokens.push_back(TAG_IDCHAR);
				if (is_letter_byte(b)) begin
					pending_tokens.push_back(TAG_IDCHAR);
					lex_clear();
					lex_mode = LM_IDENT;
					return;
				end
				pending_tokens.push_back(TAG_IDEND);
			end
			LM_IDENT: begin
				if (is_letter_byte(b)) begin
					pending_tokens.push_back(TAG_IDCHAR);
					return;
				end
				pending_tokens.push_back(TAG_IDEND);
			end
			LM_INT, LM_VARNUM: begin
				if (is_digit_byte(b)) begin
					lex_add_digit(b);
					return;
				end
				if (lex_mode == LM_INT)
					pending_tokens.push_back(TAG_INT);
				else
					pending_tokens.push_back(TAG_VARNUM);
			end
			LM_DOLLAR: begin
				if (is_digit_byte(b)) begin
					lex_mode = LM_VARNUM;
					lex_add_digit(b);
					return;
				end
				// the word after a bare dollar is swallowed unless it ends the text
				pending_tokens.push_back(TAG_UNKNOWN);
				lex_clear();
				lex_mode = LM_ERROR;
				if (b != CH_NUL)
					return;
			end
			LM_ERROR: begin
				if (b != CH_NUL)
					return;
			end
			default: ;
		endcase
		if (b == CH_NUL) begin
			pending_tokens.push_back(TAG_END);
			lex_clear();
		end else begin
			lex_start(b);
		end
	endfunction

	// Offer one word and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		bit took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		bytes_taken++;
		lex_byte(b);
	endtask

	task automatic flush_text();
		while (text_buf.size() != 0)
			send_byte(text_buf.pop_front());
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	// Text building
	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	function automatic void put_digits(int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 9));
			text_buf.push_back(c + 8'h30);
		end
	endfunction

	function automatic void put_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		text_buf.push_back(c + ($urandom_range(0, 1) ? 8'h61 : 8'h41));
	endfunction

	function automatic void put_token();
		string kw;
		int    n;
		logic [7:0] c;
		case ($urandom_range(0, 12))
			0: put_str("call");
			1: put_str("makeproc");
			2, 3: begin
				// broken keyword, followed by whatever comes next
				kw = $urandom_range(0, 1) ? "makeproc" : "call";
				n  = $urandom_range(1, kw.len() - 1);
				put_str(kw.substr(0, n - 1));
				if ($urandom_range(0, 1))
					put_letter();
			end
			4, 5: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					put_letter();
			end
			6: put_digits($urandom_range(1, 4));
			7: begin
				case ($urandom_range(0, 3))
					0: put_str("9223372036854775807");
					1: put_str("9223372036854775808");
					2: put_str("922337203685477580");
					default: put_digits($urandom_range(17, 21));
				endcase
			end
			8: begin
				put_str("$");
				put_digits($urandom_range(1, 5));
			end
			9: begin
				put_str("$");
				c = 8'($urandom_range(0, 3));
				case (c)
					0: put_letter();
					1: text_buf.push_back(CH_SPACE);
					2: text_buf.push_back(CH_EQUAL);
					default: text_buf.push_back(CH_DOLLAR);
				endcase
			end
			10, 11: begin
				case ($urandom_range(0, 3))
					0: text_buf.push_back(CH_NL);
					1: text_buf.push_back(CH_EQUAL);
					2: text_buf.push_back(CH_COLON);
					default: text_buf.push_back(CH_QUERY);
				endcase
			end
			default: begin
				c = 8'($urandom_range(1, 255));
				text_buf.push_back(c);
			end
		endcase
		if ($urandom_range(0, 1))
			text_buf.push_back(CH_SPACE);
	endfunction

	// Short texts covering single characters, keywords and the odd cases
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		put_str("=:?\n");
		put_str("callx ");
		put_str("mak1$7");
		text_buf.push_back(CH_NUL);
		put_str("$");
		text_buf.push_back(CH_NUL);
		text_buf.push_back(8'hFF);
		put_str("a");
		text_buf.push_back(CH_NUL);
		flush_text();
		stop_sending();
		wait_drained();
	endtask

	// Hold the token port off while bursty words keep arriving
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		stall_left = 300;
		@(posedge clk);
		for (int i = 0; i < 6; i++)
			put_str("makepro=");
		text_buf.push_back(CH_NUL);
		flush_text();
		stop_sending();
		wait_drained();
	endtask

	// Random texts under one idling pattern
	task automatic test_random_text(input int idle_pct, input int stall_pct, input int n_bytes);
		int stop_at;
		int n;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = bytes_taken + n_bytes;
		while (bytes_taken < stop_at) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				put_token();
			text_buf.push_back(CH_NUL);
			flush_text();
		end
		stop_sending();
		wait_drained();
	endtask

	// Token port: stall at random, or hold off for a counted stretch
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare each taken token with the oldest prediction
	always begin : token_check
		bit         took;
		logic [3:0] seen;
		tag_t       want;
		@(negedge clk);
		took = out_valid && out_ready;
		seen = token_tag;
		@(posedge clk);
		if (took) begin
			if (pending_tokens.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: unexpected token %0d", $realtime, seen);
			end else begin
				want = pending_tokens.pop_front();
				if (seen !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: token mismatch, expected %0d (%s), got %0d",
							$realtime, want, want.name(), seen);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		text_byte      = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		stall_left     = 0;
		bytes_taken    = 0;
		fail_count     = 0;
		cycle_count    = 0;
		lex_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_text(0, 0, 85);
		test_random_text(71, 0, 85);
		test_random_text(0, 71, 85);
		test_random_text(13, 13, 85);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
